// ----- rtl/u8bmp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8bmp_pkg
// Shared types and constants of the UTF-8 to BMP decoder.
// ----------------------------------------------------------------------------
package u8bmp_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNK_CODE = 1'b1;

  // configuration reset values
  localparam logic [CODE_W-1:0] ERR_CODE_RST = 16'hFFFD;
  localparam logic [CODE_W-1:0] UNK_CODE_RST = 16'h003F;

  // sequence lengths
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // code point limits
  localparam logic [CODE_W-1:0] MIN_TWO_BYTE   = 16'h0080;
  localparam logic [CODE_W-1:0] MIN_THREE_BYTE = 16'h0800;
  localparam logic [CODE_W-1:0] SURR_LO        = 16'hD800;
  localparam logic [CODE_W-1:0] SURR_HI        = 16'hDFFF;

  // open sequence state
  typedef struct packed {
    logic [2:0]        exp_len;
    logic [1:0]        held;
    logic [CODE_W-1:0] part;
  } dec_state_t;

  // results caused by one byte: bad_cnt bad codes, then an optional tail
  typedef struct packed {
    logic [1:0]          bad_cnt;
    logic                tail;
    logic [CODE_W-1:0]   tail_code;
    logic [STATUS_W-1:0] tail_status;
  } dec_run_t;

endpackage

// ----- rtl/u8bmp_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8bmp stream interfaces
// Valid/ready channels for text bytes in and decoded codes out.
// ----------------------------------------------------------------------------
interface u8bmp_in_if;
  import u8bmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8bmp_out_if;
  import u8bmp_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   code;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  modport source (output valid, output code, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input code, input status, input last_of_run,
                  output ready);
endinterface

// ----- rtl/u8bmp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8bmp_decode
// Single-pass byte decode: next sequence state and the run of results.
// ----------------------------------------------------------------------------
module u8bmp_decode (
  input  u8bmp_pkg::dec_state_t               state,
  input  logic [u8bmp_pkg::BYTE_W-1:0]        text_byte,
  input  logic                                end_of_text,
  input  logic [u8bmp_pkg::CODE_W-1:0]        err_code,
  input  logic [u8bmp_pkg::CODE_W-1:0]        unk_code,
  output u8bmp_pkg::dec_state_t               state_nxt,
  output u8bmp_pkg::dec_run_t                 run
);
  import u8bmp_pkg::*;

  logic              is_cont;
  logic              seq_open;
  logic              take_lead;
  logic [1:0]        held_inc;
  logic [CODE_W-1:0] cp;
  logic [5:0]        cont_bits;

  assign is_cont   = (text_byte[7:6] == 2'b10);
  assign seq_open  = (state.exp_len != LEN_NONE);
  assign cont_bits = text_byte[5:0];
  assign held_inc  = state.held + 2'd1;
  assign cp        = state.part | {10'd0, cont_bits};

  always_comb begin
    state_nxt = state;
    run       = '0;
    take_lead = 1'b1;

    // continuation or break of an open sequence
    if (seq_open) begin
      if (is_cont) begin
        take_lead = 1'b0;
        // count in three bits so a fourth byte does not wrap
        if (({1'b0, state.held} + 3'd1) == state.exp_len) begin
          run.tail = 1'b1;
          if (state.exp_len == LEN_TWO) begin
            if (cp < MIN_TWO_BYTE) begin
              run.tail_code   = unk_code;
              run.tail_status = ST_UNKNOWN;
            end else begin
              run.tail_code   = cp;
              run.tail_status = ST_VALID;
            end
          end else if (state.exp_len == LEN_THREE) begin
            if (cp < MIN_THREE_BYTE || (cp >= SURR_LO && cp <= SURR_HI)) begin
              run.tail_code   = unk_code;
              run.tail_status = ST_UNKNOWN;
            end else begin
              run.tail_code   = cp;
              run.tail_status = ST_VALID;
            end
          end else begin
            run.tail_code   = err_code;
            run.tail_status = ST_BAD;
          end
          state_nxt = '0;
        end else begin
          if (state.exp_len == LEN_THREE) begin
            state_nxt.part = state.part | {4'd0, cont_bits, 6'd0};
          end
          state_nxt.held = held_inc;
          if (end_of_text) begin
            run.bad_cnt = held_inc;
            state_nxt   = '0;
          end
        end
      end else begin
        run.bad_cnt = state.held;
        state_nxt   = '0;
      end
    end

    // byte taken as a new lead
    if (take_lead) begin
      if (text_byte == '0) begin
        // end of text, no result of its own
      end else if (text_byte[7] == 1'b0) begin
        run.tail        = 1'b1;
        run.tail_code   = {8'd0, text_byte};
        run.tail_status = ST_VALID;
      end else if (text_byte[7:5] == 3'b110) begin
        state_nxt.exp_len = LEN_TWO;
        state_nxt.held    = 2'd1;
        state_nxt.part    = {5'd0, text_byte[4:0], 6'd0};
      end else if (text_byte[7:4] == 4'b1110) begin
        state_nxt.exp_len = LEN_THREE;
        state_nxt.held    = 2'd1;
        state_nxt.part    = {text_byte[3:0], 12'd0};
      end else if (text_byte[7:3] == 5'b11110) begin
        state_nxt.exp_len = LEN_FOUR;
        state_nxt.held    = 2'd1;
        state_nxt.part    = '0;
      end else begin
        run.tail        = 1'b1;
        run.tail_code   = err_code;
        run.tail_status = ST_BAD;
      end
      // a fresh lead on the final byte is flushed at once
      if (end_of_text && state_nxt.exp_len != LEN_NONE) begin
        run.tail        = 1'b1;
        run.tail_code   = err_code;
        run.tail_status = ST_BAD;
        state_nxt       = '0;
      end
    end
  end

endmodule

// ----- rtl/utf8_to_bmp_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_bmp_decoder
// UTF-8 byte stream to 16-bit BMP codes, with configurable error codes.
// ----------------------------------------------------------------------------
// usage:
//   in_chan takes one text byte per transfer, with end_of_text on the final
//   byte; a zero byte also ends the text. out_chan gives one code per
//   transfer, with status and last_of_run marking the final code a byte
//   caused. bytes that only extend a sequence give no code.
//   cfg_we/cfg_idx/cfg_wdata write the error code (index 0) and the unknown
//   code (index 1); the user must do so only while the block is idle, which
//   the block itself does not enforce. a byte taken goes into the input
//   register, is decoded from there into the result register when that is
//   free, and its first code is offered from it. one byte per cycle while
//   each byte gives at most one code and out_chan is ready; a byte that gives
//   more codes holds the result register, drained one code per transfer.
//   an input register in front lets one byte wait while results stall.
//   reset: both channels empty, no sequence open, codes back to FFFD / 003F.
//   stall: out_chan holds its code; one more byte is taken, then in_chan
//   ready drops until the result register frees.
// ----------------------------------------------------------------------------
module utf8_to_bmp_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  u8bmp_in_if.sink                             in_chan,
  u8bmp_out_if.source                          out_chan,
  input  logic                                 cfg_we,
  input  logic [u8bmp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [u8bmp_pkg::CODE_W-1:0]         cfg_wdata
);
  import u8bmp_pkg::*;

  logic [CODE_W-1:0]   err_code_r;
  logic [CODE_W-1:0]   unk_code_r;

  logic                ib_vld_r;
  logic [BYTE_W-1:0]   ib_byte_r;
  logic                ib_eot_r;

  dec_state_t          st_r;
  dec_state_t          st_nxt;
  dec_run_t            dec_run;

  logic [1:0]          rn_bad_r;
  logic                rn_tail_r;
  logic [CODE_W-1:0]   rn_code_r;
  logic [STATUS_W-1:0] rn_status_r;

  logic                busy;
  logic                out_xfer;
  logic                last_beat;
  logic                run_free;
  logic                dec_go;
  logic                in_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_code_r <= ERR_CODE_RST;
      unk_code_r <= UNK_CODE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ERR_CODE) begin
        err_code_r <= cfg_wdata;
      end else begin
        unk_code_r <= cfg_wdata;
      end
    end
  end

  // handshake control
  assign busy      = (rn_bad_r != 2'd0) || rn_tail_r;
  assign out_xfer  = busy && out_chan.ready;
  assign last_beat = ((rn_bad_r == 2'd1) && !rn_tail_r) ||
                     ((rn_bad_r == 2'd0) && rn_tail_r);
  assign run_free  = !busy || (out_xfer && last_beat);
  assign dec_go    = ib_vld_r && run_free;
  assign in_chan.ready = !ib_vld_r || run_free;
  assign in_xfer   = in_chan.valid && in_chan.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_vld_r <= 1'b0;
    end else if (in_xfer) begin
      ib_vld_r <= 1'b1;
    end else if (dec_go) begin
      ib_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ib_byte_r <= in_chan.text_byte;
      ib_eot_r  <= in_chan.end_of_text;
    end
  end

  // byte decode
  u8bmp_decode u_decode (
    .state        (st_r),
    .text_byte    (ib_byte_r),
    .end_of_text  (ib_eot_r),
    .err_code     (err_code_r),
    .unk_code     (unk_code_r),
    .state_nxt    (st_nxt),
    .run          (dec_run)
  );

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (dec_go) begin
      st_r <= st_nxt;
    end
  end

  // result register, drained one code per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rn_bad_r  <= 2'd0;
      rn_tail_r <= 1'b0;
    end else if (dec_go) begin
      rn_bad_r  <= dec_run.bad_cnt;
      rn_tail_r <= dec_run.tail;
    end else if (out_xfer) begin
      if (rn_bad_r != 2'd0) begin
        rn_bad_r <= rn_bad_r - 2'd1;
      end else begin
        rn_tail_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_go) begin
      rn_code_r   <= dec_run.tail_code;
      rn_status_r <= dec_run.tail_status;
    end
  end

  // output channel
  assign out_chan.valid       = busy;
  assign out_chan.code        = (rn_bad_r != 2'd0) ? err_code_r : rn_code_r;
  assign out_chan.status      = (rn_bad_r != 2'd0) ? ST_BAD : rn_status_r;
  assign out_chan.last_of_run = last_beat;

`ifndef SYNTH
  // held byte count stays inside the open sequence
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.exp_len == LEN_NONE) ? (st_r.held == 2'd0)
                               : ((st_r.held != 2'd0) && ({1'b0, st_r.held} < st_r.exp_len)))
    else $error("held count out of range for open sequence");

  // only legal sequence lengths are ever open
  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.exp_len == LEN_NONE || st_r.exp_len == LEN_TWO ||
    st_r.exp_len == LEN_THREE || st_r.exp_len == LEN_FOUR)
    else $error("illegal open sequence length");

  // a waiting byte is not dropped while results are still pending
  a_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (ib_vld_r && !run_free) |=> ib_vld_r)
    else $error("waiting byte lost during result stall");

  // the last code of a run with nothing behind it empties the output
  a_run_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && last_beat && !ib_vld_r) |=> !out_chan.valid)
    else $error("output still valid after last code of run");
`endif

endmodule

// ----- tb/utf8_to_bmp_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_bmp_decoder_test
// Drives UTF-8 text bytes into the decoder under random valid/ready gaps and
// checks every code that comes out against a byte-level decoder model kept in
// a scoreboard. Both code registers are rewritten between phases.
// ----------------------------------------------------------------------------
module utf8_to_bmp_decoder_test;
  import u8bmp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_BYTES    = 98;
  localparam int unsigned HOLD_OFF       = 60;

  // one expected code
  typedef struct {
    logic [CODE_W-1:0]   code;
    logic [STATUS_W-1:0] status;
    logic                last;
  } code_rec_t;

  // decoder model and queue of expected codes
  class decode_board;
    logic [CODE_W-1:0] err_code;
    logic [CODE_W-1:0] unk_code;
    logic [2:0]        seq_len;
    int                held;
    logic [CODE_W-1:0] part_cp;
    code_rec_t         pending_codes[$];
    code_rec_t         run_buf[4];
    int                run_len;
    int                errors;

    function new();
      err_code = ERR_CODE_RST;
      unk_code = UNK_CODE_RST;
      seq_len  = LEN_NONE;
      held     = 0;
      part_cp  = '0;
      run_len  = 0;
      errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CODE_W-1:0] value);
      if (idx == CFG_ERR_CODE) err_code = value;
      else unk_code = value;
    endfunction

    function void add(logic [CODE_W-1:0] code, logic [STATUS_W-1:0] status);
      run_buf[run_len] = '{code, status, 1'b0};
      run_len++;
    endfunction

    // one bad code per held byte, then no sequence open
    function void flush(int count);
      for (int i = 0; i < count; i++) add(err_code, ST_BAD);
      seq_len = LEN_NONE;
      held    = 0;
      part_cp = '0;
    endfunction

    // expected codes for one accepted text byte
    function void note_byte(logic [BYTE_W-1:0] b, logic eot);
      logic [CODE_W-1:0] cp;
      code_rec_t         rec;
      bit                lead;
      run_len = 0;
      lead    = 1'b1;
      if (seq_len != LEN_NONE) begin
        if (b[7:6] == 2'b10) begin
          lead = 1'b0;
          if (held + 1 == seq_len) begin
            cp = part_cp | {10'd0, b[5:0]};
            case (seq_len)
              LEN_TWO: begin
                if (cp < MIN_TWO_BYTE) add(unk_code, ST_UNKNOWN);
                else add(cp, ST_VALID);
              end
              LEN_THREE: begin
                if (cp < MIN_THREE_BYTE || (cp >= SURR_LO && cp <= SURR_HI))
                  add(unk_code, ST_UNKNOWN);
                else add(cp, ST_VALID);
              end
              // four-byte sequences lie outside the BMP
              default: add(err_code, ST_BAD);
            endcase
            seq_len = LEN_NONE;
            held    = 0;
            part_cp = '0;
          end else begin
            if (seq_len == LEN_THREE) part_cp = part_cp | {4'd0, b[5:0], 6'd0};
            held = (held + 1) & 3;
            if (eot) flush(held);
          end
        end else begin
          // sequence broken: held bytes go out as bad codes
          flush(held);
        end
      end
      if (lead) begin
        if (b == 8'h00) begin
          // zero byte ends the text, no code of its own
        end else if (b[7] == 1'b0) begin
          add({8'd0, b}, ST_VALID);
        end else if (b[7:5] == 3'b110) begin
          seq_len = LEN_TWO;
          held    = 1;
          part_cp = {5'd0, b[4:0], 6'd0};
        end else if (b[7:4] == 4'b1110) begin
          seq_len = LEN_THREE;
          held    = 1;
          part_cp = {b[3:0], 12'd0};
        end else if (b[7:3] == 5'b11110) begin
          seq_len = LEN_FOUR;
          held    = 1;
          part_cp = '0;
        end else begin
          add(err_code, ST_BAD);
        end
        if (eot && seq_len != LEN_NONE) flush(held);
      end
      for (int i = 0; i < run_len; i++) begin
        rec      = run_buf[i];
        rec.last = (i == run_len - 1);
        pending_codes.push_back(rec);
      end
    endfunction

    // compare one code transfer with the oldest expectation
    function void check_code(logic [CODE_W-1:0] code, logic [STATUS_W-1:0] status,
                             logic last);
      code_rec_t want;
      if (pending_codes.size() == 0) begin
        $error("unexpected code %h status %0d last_of_run %0d", code, status, last);
        errors++;
        return;
      end
      want = pending_codes.pop_front();
      if (code !== want.code) begin
        $error("code mismatch: expected %h, got %h", want.code, code);
        errors++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run mismatch: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CODE_W-1:0]    cfg_wdata;

  u8bmp_in_if  in_if ();
  u8bmp_out_if out_if ();

  decode_board board;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_req;
  int          quiet_cycles;
  int          phase_bytes;

  utf8_to_bmp_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_req--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) board.note_byte(in_if.text_byte, in_if.end_of_text);
      if (out_if.valid && out_if.ready)
        board.check_code(out_if.code, out_if.status, out_if.last_of_run);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // offer one byte after a random gap, return at the transfer edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.text_byte   <= b;
    in_if.end_of_text <= eot;
    do @(posedge clk); while (!in_if.ready);
    phase_bytes++;
  endtask

  function automatic logic [BYTE_W-1:0] lead_byte(int len);
    case (len)
      2:       return BYTE_W'($urandom_range(8'hC0, 8'hDF));
      3:       return BYTE_W'($urandom_range(8'hE0, 8'hEF));
      default: return BYTE_W'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // one random character: mostly well-formed, some broken or noise
  task automatic send_random_char();
    int kind;
    int len;
    int keep;
    bit early;
    kind = $urandom_range(99);
    if (kind < 25) begin
      send_byte(BYTE_W'($urandom_range(1, 127)), $urandom_range(15) == 0);
    end else if (kind < 72) begin
      len = (kind < 45) ? 2 : (kind < 65) ? 3 : 4;
      send_byte(lead_byte(len), 1'b0);
      for (int i = 1; i < len; i++)
        send_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)),
                  (i == len - 1) && ($urandom_range(15) == 0));
    end else if (kind < 82) begin
      // cut short: either ended by end_of_text or left for the next byte to break
      len   = $urandom_range(2, 4);
      keep  = $urandom_range(0, len - 2);
      early = (kind < 77);
      send_byte(lead_byte(len), early && keep == 0);
      for (int i = 1; i <= keep; i++)
        send_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)), early && i == keep);
    end else if (kind < 87) begin
      send_byte(8'h00, 1'($urandom_range(1)));
    end else if (kind < 93) begin
      if ($urandom_range(1))
        send_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)), 1'($urandom_range(1)));
      else
        send_byte(BYTE_W'($urandom_range(8'hF8, 8'hFF)), 1'($urandom_range(1)));
    end else begin
      send_byte(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  // stop offering, wait for all codes and for bytes still in flight
  task automatic end_phase();
    in_if.valid <= 1'b0;
    // let the monitor note the last transfer first
    @(posedge clk);
    while (board.pending_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // main sequence
  initial begin
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    quiet_cycles   = 0;
    phase_bytes    = 0;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_ERR_CODE;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.text_byte   <= '0;
    in_if.end_of_text <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed text at reset codes
    send_byte(8'h7F, 1'b0);
    // two-byte valid, then overlong
    send_byte(8'hC3, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    // three-byte overlong, surrogate, top of the BMP
    send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // complete four-byte sequence
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    // stray continuation and invalid lead
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
    // sequence broken by a new lead
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
    // three held bytes flushed by a zero byte
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    // early end on a lead
    send_byte(8'hC3, 1'b1);
    end_phase();

    // random phases, each with its own idling and code registers
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case (p)
        0: begin write_reg(CFG_ERR_CODE, 16'hFFFF); write_reg(CFG_UNK_CODE, 16'h0000); end
        1: begin write_reg(CFG_ERR_CODE, 16'h0000); write_reg(CFG_UNK_CODE, 16'hFFFF); end
        default: begin
          write_reg(CFG_ERR_CODE, CODE_W'($urandom_range(16'hFFFF)));
          write_reg(CFG_UNK_CODE, CODE_W'($urandom_range(16'hFFFF)));
        end
      endcase
      // long receiver hold-off so the input side backs up
      if (p == 0) hold_req = HOLD_OFF;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_random_char();
      end_phase();
    end

    if (board.pending_codes.size() != 0) begin
      $error("%0d expected codes never arrived", board.pending_codes.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
